### hdl/purge_target_period_tracker_assert.svh
// Assertion macros for the purge target period tracker.
`ifndef PURGE_TARGET_PERIOD_TRACKER_ASSERT_SVH
`define PURGE_TARGET_PERIOD_TRACKER_ASSERT_SVH

`ifndef SYNTH

// Check that a condition holds at every clock edge out of reset.
`define PTT_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define PTT_CHECK_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`else

`define PTT_CHECK(lbl, cond, msg)
`define PTT_CHECK_NEXT(lbl, trig, cond, msg)

`endif

`endif

### hdl/ptt_pkg.sv
// Types and constants shared by the purge target period tracker.
package ptt_pkg;

  // Field widths
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned SECONDS_W = 16;
  localparam int unsigned PERIOD_W  = 46;   // fits 65535 s in nanoseconds
  localparam int unsigned TICK_W    = 64;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_SECONDS     = 2'd0,
    REG_CLOCK_IS_MONOTONIC = 2'd1
  } ptt_reg_t;

  // Constants
  localparam logic [PERIOD_W-1:0] NS_PER_SECOND   = PERIOD_W'(64'd1000000000);
  localparam logic [SECONDS_W-1:0] PERIOD_SECONDS_RST = SECONDS_W'(10);
  localparam logic [PERIOD_W-1:0] PERIOD_NS_RST =
    PERIOD_W'(64'd1000000000 * 64'd10);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam int unsigned MAX_SHARDS_DEF = 64;

  // Input transaction
  typedef struct packed {
    logic [COUNT_W-1:0] shard_active;
    logic [COUNT_W-1:0] shard_dirty;
    logic               has_stats;
    logic [TIME_W-1:0]  now_ns;
    logic               last_shard;
  } ptt_in_t;

  // Result transaction
  typedef struct packed {
    logic [SUM_W-1:0] purge_target;
    logic             period_restarted;
  } ptt_out_t;

endpackage

### hdl/purge_target_period_tracker.sv
// Purge target period tracker: shard sums, period peaks and purge target.
// Takes one shard transaction per clock cycle, with no gaps between ticks, while the pipeline
// does not stall; the rate is set by the per-shard saturating add into the running sums. Only
// the transaction marked last_shard yields a result, carried from the input register through
// a stage for the sums and the time window, a stage for the period restart and peak update,
// and the output register with the purge target. The stages hold under output back-pressure
// and only a waiting last transaction can hold off the input. Configuration writes take
// effect on the next cycle; the period is converted to nanoseconds as it is written.
`include "purge_target_period_tracker_assert.svh"

module purge_target_period_tracker #(
  parameter int unsigned MAX_SHARDS = ptt_pkg::MAX_SHARDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ptt_pkg::ptt_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ptt_pkg::ptt_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ptt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptt_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned SEEN_W = $clog2(MAX_SHARDS + 1);

  // Configuration
  logic [ptt_pkg::PERIOD_W-1:0] period_ns_r;
  logic                         mono_r;

  // Running state
  logic [ptt_pkg::SUM_W-1:0]  active_total_r, active_total_nxt;
  logic [ptt_pkg::SUM_W-1:0]  dirty_total_r, dirty_total_nxt;
  logic [SEEN_W-1:0]          shard_seen_r, shard_seen_nxt;
  logic [ptt_pkg::TICK_W-1:0] tick_count_r, tick_count_nxt;
  logic [ptt_pkg::TIME_W-1:0] epoch_begin_r, epoch_begin_nxt;
  logic [ptt_pkg::SUM_W-1:0]  current_peak_r, current_peak_nxt;
  logic [ptt_pkg::SUM_W-1:0]  prior_peak_r, prior_peak_nxt;

  // Input stage
  logic             s1_v_r;
  ptt_pkg::ptt_in_t s1_r;

  // Sum stage (last transactions only)
  logic                       s2_v_r;
  logic [ptt_pkg::SUM_W-1:0]  s2_act_r;
  logic [ptt_pkg::SUM_W-1:0]  s2_dir_r;
  logic [ptt_pkg::TIME_W-1:0] s2_now_r;
  logic [ptt_pkg::TIME_W-1:0] s2_ago_r;

  // Peak stage
  logic                       s3_v_r;
  logic [ptt_pkg::SUM_W:0]    s3_touched_r;
  logic [ptt_pkg::SUM_W-1:0]  s3_prior_r;
  logic [ptt_pkg::SUM_W-1:0]  s3_cur_r;
  logic                       s3_restart_r;

  // Output register
  logic              out_v_r;
  ptt_pkg::ptt_out_t out_r;

  // Flow control between stages
  logic out_go, s3_free, s2_free, s1_free, s1_adv, s2_adv, s3_adv, in_acc;

  assign out_go  = !out_v_r || out_ready;
  assign s3_adv  = s3_v_r && out_go;
  assign s3_free = !s3_v_r || out_go;
  assign s2_adv  = s2_v_r && s3_free;
  assign s2_free = !s2_v_r || s3_free;
  assign s1_adv  = s1_v_r && (!s1_r.last_shard || s2_free);
  assign s1_free = !s1_v_r || !s1_r.last_shard || s2_free;
  assign in_ready = s1_free;
  assign in_acc   = in_valid && in_ready;

  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Configuration registers; convert the period to nanoseconds on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_ns_r <= ptt_pkg::PERIOD_NS_RST;
      mono_r      <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        ptt_pkg::REG_PERIOD_SECONDS: begin
          period_ns_r <= ptt_pkg::PERIOD_W'(cfg_data[ptt_pkg::SECONDS_W-1:0])
                         * ptt_pkg::NS_PER_SECOND;
        end
        ptt_pkg::REG_CLOCK_IS_MONOTONIC: begin
          mono_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Accumulate shard counts with saturation; clear at the end of a tick
  logic                      s1_take;
  logic [ptt_pkg::SUM_W:0]   act_sum, dir_sum;
  logic [ptt_pkg::SUM_W-1:0] act_new, dir_new;

  always_comb begin
    s1_take = s1_r.has_stats && (shard_seen_r < SEEN_W'(MAX_SHARDS));
    act_sum = {1'b0, active_total_r} + (ptt_pkg::SUM_W + 1)'(s1_r.shard_active);
    dir_sum = {1'b0, dirty_total_r} + (ptt_pkg::SUM_W + 1)'(s1_r.shard_dirty);
    act_new = active_total_r;
    dir_new = dirty_total_r;
    if (s1_take) begin
      act_new = act_sum[ptt_pkg::SUM_W] ? ptt_pkg::SUM_MAX : act_sum[ptt_pkg::SUM_W-1:0];
      dir_new = dir_sum[ptt_pkg::SUM_W] ? ptt_pkg::SUM_MAX : dir_sum[ptt_pkg::SUM_W-1:0];
    end

    active_total_nxt = active_total_r;
    dirty_total_nxt  = dirty_total_r;
    shard_seen_nxt   = shard_seen_r;
    tick_count_nxt   = tick_count_r;
    if (s1_adv) begin
      if (s1_r.last_shard) begin
        active_total_nxt = '0;
        dirty_total_nxt  = '0;
        shard_seen_nxt   = '0;
        tick_count_nxt   = tick_count_r + 1'b1;
      end else begin
        active_total_nxt = act_new;
        dirty_total_nxt  = dir_new;
        if (shard_seen_r < SEEN_W'(MAX_SHARDS)) begin
          shard_seen_nxt = shard_seen_r + 1'b1;
        end
      end
    end
  end

  // Start of the current time window, saturated at zero
  logic [ptt_pkg::TIME_W:0]   ago_diff;
  logic [ptt_pkg::TIME_W-1:0] ago;

  always_comb begin
    ago_diff = {1'b0, s1_r.now_ns} - (ptt_pkg::TIME_W + 1)'(period_ns_r);
    ago      = ago_diff[ptt_pkg::TIME_W] ? '0 : ago_diff[ptt_pkg::TIME_W-1:0];
  end

  // Decide the period restart and move the peaks
  logic restart;

  always_comb begin
    restart = (!mono_r && (epoch_begin_r > s2_now_r)) || (epoch_begin_r <= s2_ago_r);
    epoch_begin_nxt  = epoch_begin_r;
    prior_peak_nxt   = prior_peak_r;
    current_peak_nxt = current_peak_r;
    if (s2_adv) begin
      if (restart) begin
        epoch_begin_nxt  = s2_now_r;
        prior_peak_nxt   = current_peak_r;
        current_peak_nxt = s2_act_r;
      end else if (s2_act_r > current_peak_r) begin
        current_peak_nxt = s2_act_r;
      end
    end
  end

  // Purge target from the updated peaks
  logic [ptt_pkg::SUM_W+1:0] tgt_diff;
  logic [ptt_pkg::SUM_W-1:0] tgt;

  always_comb begin
    tgt_diff = {1'b0, s3_touched_r} - (ptt_pkg::SUM_W + 2)'(s3_prior_r);
    tgt      = '0;
    if ((s3_prior_r > s3_cur_r) && !tgt_diff[ptt_pkg::SUM_W + 1]) begin
      tgt = tgt_diff[ptt_pkg::SUM_W] ? ptt_pkg::SUM_MAX : tgt_diff[ptt_pkg::SUM_W-1:0];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r         <= 1'b0;
      s2_v_r         <= 1'b0;
      s3_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      active_total_r <= '0;
      dirty_total_r  <= '0;
      shard_seen_r   <= '0;
      tick_count_r   <= '0;
      epoch_begin_r  <= '0;
      current_peak_r <= '0;
      prior_peak_r   <= '0;
    end else begin
      s1_v_r         <= in_acc || (s1_v_r && !s1_adv);
      s2_v_r         <= (s1_adv && s1_r.last_shard) || (s2_v_r && !s2_adv);
      s3_v_r         <= s2_adv || (s3_v_r && !s3_adv);
      out_v_r        <= s3_adv || (out_v_r && !out_ready);
      active_total_r <= active_total_nxt;
      dirty_total_r  <= dirty_total_nxt;
      shard_seen_r   <= shard_seen_nxt;
      tick_count_r   <= tick_count_nxt;
      epoch_begin_r  <= epoch_begin_nxt;
      current_peak_r <= current_peak_nxt;
      prior_peak_r   <= prior_peak_nxt;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_data;
    end
    if (s1_adv && s1_r.last_shard) begin
      s2_act_r <= act_new;
      s2_dir_r <= dir_new;
      s2_now_r <= s1_r.now_ns;
      s2_ago_r <= ago;
    end
    if (s2_adv) begin
      s3_touched_r <= {1'b0, s2_act_r} + {1'b0, s2_dir_r};
      s3_prior_r   <= prior_peak_nxt;
      s3_cur_r     <= current_peak_nxt;
      s3_restart_r <= restart;
    end
    if (s3_adv) begin
      out_r.purge_target     <= tgt;
      out_r.period_restarted <= s3_restart_r;
    end
  end

  // Assertions
  `PTT_CHECK(a_seen_bound, shard_seen_r <= SEEN_W'(MAX_SHARDS),
    "shard count beyond MAX_SHARDS")
  `PTT_CHECK(a_stall_cause, in_ready || (s1_v_r && s1_r.last_shard),
    "input held off without a waiting last transaction")
  `PTT_CHECK_NEXT(a_tick_clear, s1_adv && s1_r.last_shard,
    (active_total_r == '0) && (dirty_total_r == '0) && (shard_seen_r == '0),
    "sums not cleared after a tick closed")

endmodule

### test/tb_purge_target_period_tracker.sv
// Self-checking testbench for the purge target period tracker.
`timescale 1ns / 100ps

module tb_purge_target_period_tracker;

  localparam int unsigned SHARD_LIMIT  = ptt_pkg::MAX_SHARDS_DEF;
  localparam logic [63:0] NS_PER_S     = 64'd1_000_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  // ~700 transactions, each of which the random stalls may hold up
  localparam int unsigned CYCLE_LIMIT  = 200_000;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  ptt_pkg::ptt_in_t               in_data;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  ptt_pkg::ptt_out_t              out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [ptt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ptt_pkg::CFG_DATA_W-1:0] cfg_data;

  // Predictor state: configuration, tick sums and period peaks
  logic [15:0] period_s      = ptt_pkg::PERIOD_SECONDS_RST;
  logic        monotonic_clk = 1'b1;
  logic [39:0] active_sum    = '0;
  logic [39:0] dirty_sum     = '0;
  logic [63:0] window_open_ns = '0;
  logic [39:0] current_max   = '0;
  logic [39:0] older_peak    = '0;
  logic [63:0] closed_ticks  = '0;
  int          shards_in_tick = 0;

  ptt_pkg::ptt_out_t target_q[$];

  // Stimulus and bookkeeping
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic [63:0] clock_ns    = '0;
  int          mismatch_count = 0;
  int          shard_txn_count = 0;
  int          restart_count = 0;
  int          nonzero_target_count = 0;
  int          cfg_write_count = 0;
  int unsigned cycle_count = 0;

  purge_target_period_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               target_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [63:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  function automatic ptt_pkg::ptt_in_t shard_item(input logic [31:0] act,
                                                  input logic [31:0] dirty,
                                                  input logic has, input logic [63:0] now,
                                                  input logic last);
    ptt_pkg::ptt_in_t t;
    t.shard_active = act;
    t.shard_dirty  = dirty;
    t.has_stats    = has;
    t.now_ns       = now;
    t.last_shard   = last;
    return t;
  endfunction

  // Fold one shard transaction into the tick; on the closing shard, return the purge target
  function automatic bit fold_shard(input ptt_pkg::ptt_in_t t, output ptt_pkg::ptt_out_t res);
    logic [40:0] sum;
    logic [63:0] span_ns;
    logic [63:0] window_start;
    logic [40:0] touched;
    logic [40:0] excess;
    bit          restart;
    res = '0;
    if (t.has_stats && shards_in_tick < SHARD_LIMIT) begin
      sum = {1'b0, active_sum} + 41'(t.shard_active);
      active_sum = sum[40] ? ptt_pkg::SUM_MAX : sum[39:0];
      sum = {1'b0, dirty_sum} + 41'(t.shard_dirty);
      dirty_sum = sum[40] ? ptt_pkg::SUM_MAX : sum[39:0];
    end
    if (shards_in_tick < SHARD_LIMIT) shards_in_tick++;
    if (!t.last_shard) return 1'b0;

    closed_ticks++;
    span_ns = 64'(period_s) * NS_PER_S;
    window_start = (t.now_ns >= span_ns) ? t.now_ns - span_ns : 64'd0;
    restart = (!monotonic_clk && window_open_ns > t.now_ns) || (window_open_ns <= window_start);

    // Roll the peaks on a new period, else track the highest active sum
    if (restart) begin
      window_open_ns = t.now_ns;
      older_peak     = current_max;
      current_max    = active_sum;
    end else if (active_sum > current_max) begin
      current_max = active_sum;
    end

    res.period_restarted = restart;
    if (older_peak > current_max) begin
      touched = {1'b0, active_sum} + {1'b0, dirty_sum};
      if (touched > {1'b0, older_peak}) begin
        excess = touched - {1'b0, older_peak};
        res.purge_target = excess[40] ? ptt_pkg::SUM_MAX : excess[39:0];
      end
    end

    active_sum     = '0;
    dirty_sum      = '0;
    shards_in_tick = 0;
    return 1'b1;
  endfunction

  // Predict on accepted shards, track register writes, check each result transaction
  always @(posedge clk) begin
    ptt_pkg::ptt_out_t res;
    ptt_pkg::ptt_out_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        cfg_write_count++;
        case (cfg_index)
          ptt_pkg::REG_PERIOD_SECONDS:     period_s = cfg_data;
          ptt_pkg::REG_CLOCK_IS_MONOTONIC: monotonic_clk = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        shard_txn_count++;
        if (fold_shard(in_data, res)) target_q.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (target_q.size() == 0) begin
          $error("Unexpected result: purge_target %0d, period_restarted %0d",
                 out_data.purge_target, out_data.period_restarted);
          mismatch_count++;
        end else begin
          want = target_q.pop_front();
          if (want.period_restarted) restart_count++;
          if (want.purge_target != 0) nonzero_target_count++;
          if (out_data.purge_target !== want.purge_target) begin
            $error("purge_target mismatch: expected %0d, actual %0d",
                   want.purge_target, out_data.purge_target);
            mismatch_count++;
          end
          if (out_data.period_restarted !== want.period_restarted) begin
            $error("period_restarted mismatch: expected %0d, actual %0d",
                   want.period_restarted, out_data.period_restarted);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Send one shard transaction; called and returns at a falling edge
  task automatic send_shard(input ptt_pkg::ptt_in_t item);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (target_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write both registers back to back; only called while the block is idle
  task automatic set_config(input logic [15:0] seconds, input logic monotonic);
    cfg_valid <= 1'b1;
    cfg_index <= ptt_pkg::REG_PERIOD_SECONDS;
    cfg_data  <= seconds;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= ptt_pkg::REG_CLOCK_IS_MONOTONIC;
    cfg_data  <= ptt_pkg::CFG_DATA_W'(monotonic);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Default 10 s period: open, grow, roll over, purge, and backward time on a monotonic clock
  task automatic test_period_rollover();
    // empty tick opens the first period
    send_shard(shard_item(32'd0, 32'd0, 1'b0, 64'd5_000_000_000, 1'b1));
    // largest shard counts raise the current peak
    repeat (2) send_shard(shard_item('1, '1, 1'b1, 64'd0, 1'b0));
    send_shard(shard_item('1, '1, 1'b1, 64'd6_000_000_000, 1'b1));
    // period elapsed: peak moves to prior, small active sum becomes current
    send_shard(shard_item(32'd5, 32'h7FFF_FFFF, 1'b1, 64'd16_000_000_000, 1'b1));
    // dirty pages push the total past the prior peak
    repeat (3) send_shard(shard_item(32'd0, '1, 1'b1, 64'd0, 1'b0));
    send_shard(shard_item(32'd0, '1, 1'b1, 64'd17_000_000_000, 1'b1));
    // time runs backwards, ignored on a monotonic clock
    send_shard(shard_item(32'd1, 32'd1, 1'b1, 64'd1_000_000_000, 1'b1));
    wait_drained();
  endtask

  // Zero period on a clock that may run backwards: every tick restarts
  task automatic test_zero_period();
    set_config(16'd0, 1'b0);
    send_shard(shard_item(32'd7, 32'd3, 1'b1, 64'd1_000_000_000, 1'b1));
    send_shard(shard_item(32'd2, 32'd9, 1'b1, 64'd1_000_000_000, 1'b1));
    // counts without stats are ignored; latest possible timestamp
    send_shard(shard_item('1, '1, 1'b0, 64'd0, 1'b0));
    send_shard(shard_item('1, '1, 1'b0, '1, 1'b1));
    wait_drained();
  endtask

  // Longest period: backward restart, a tick within the period, and one at the end of time
  task automatic test_longest_period();
    set_config(16'hFFFF, 1'b0);
    send_shard(shard_item(32'd100, 32'd0, 1'b1, 64'd0, 1'b1));
    send_shard(shard_item(32'd50, 32'd10, 1'b1, 64'd100, 1'b1));
    send_shard(shard_item(32'd20, 32'd500, 1'b1, 64'd200, 1'b1));
    send_shard(shard_item(32'd1, 32'd1, 1'b1, '1, 1'b1));
    wait_drained();
  endtask

  // Random ticks of random length with a clock that mostly advances relative to the period
  task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct,
                                     input logic [15:0] seconds, input logic monotonic);
    logic [63:0] span_ns;
    logic [31:0] act_mask;
    logic [31:0] dirty_mask;
    int          sent;
    int          shards;
    bit          empty_tick;
    sent    = 0;
    span_ns = 64'(seconds) * NS_PER_S;
    set_config(seconds, monotonic);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (sent < n_items) begin
      // usually a few shards, sometimes an empty tick or a long one around the shard limit
      empty_tick = ($urandom_range(19) == 0);
      if (empty_tick) shards = 1;
      else if ($urandom_range(39) == 0) shards = $urandom_range(72, 60);
      else shards = $urandom_range(6, 1);
      act_mask   = 32'hFFFF_FFFF >> (8 * $urandom_range(3));
      dirty_mask = 32'hFFFF_FFFF >> (8 * $urandom_range(3));

      // advance the clock within or past the period, step back, or jump anywhere
      case ($urandom_range(9))
        0, 1, 2, 3: clock_ns += wide_random() % (span_ns / 4 + 1);
        4, 5:       clock_ns += span_ns + wide_random() % (span_ns / 4 + 1);
        6:          clock_ns -= wide_random() % (clock_ns / 2 + 1);
        7:          ;
        8:          clock_ns = wide_random();
        default:    clock_ns += $urandom_range(1000);
      endcase

      for (int i = 0; i < shards; i++) begin
        send_shard(shard_item($urandom & act_mask, $urandom & dirty_mask,
                              !empty_tick && $urandom_range(9) != 0,
                              (i == shards - 1) ? clock_ns : wide_random(),
                              i == shards - 1));
      end
      sent += shards;
    end
    wait_drained();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = ptt_pkg::REG_PERIOD_SECONDS;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_config(ptt_pkg::PERIOD_SECONDS_RST, 1'b1);
    test_period_rollover();
    test_zero_period();
    test_longest_period();

    test_random_traffic(110, 20, 52, 16'd1, 1'b0);
    test_random_traffic(110, 20, 52, 16'hFFFF, 1'b1);
    test_random_traffic(110, 52, 20, 16'd0, 1'b1);
    test_random_traffic(110, 52, 20, 16'($urandom_range(30, 2)), 1'b0);
    test_random_traffic(110, 0, 0, ptt_pkg::PERIOD_SECONDS_RST, 1'b1);
    test_random_traffic(110, 0, 0, 16'($urandom), 1'($urandom));

    if (target_q.size() != 0) begin
      $error("%0d expected results never arrived", target_q.size());
      mismatch_count++;
    end

    $display("Run covered %0d shard transactions in %0d ticks and %0d register writes.",
             shard_txn_count, closed_ticks, cfg_write_count);
    $display("Results held %0d period restarts and %0d nonzero purge targets.",
             restart_count, nonzero_target_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/ptt_pkg.sv
hdl/purge_target_period_tracker.sv
test/tb_purge_target_period_tracker.sv
